/* src/imh_pkg.sv */
package imh_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_CHANGE  = 2'd2,
    CMD_ERASE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_STALE = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_CHK2,
    S_INS,
    S_EXT_RD,
    S_EXT_WR,
    S_ERA_RD,
    S_ERA_WR,
    S_CHG,
    S_UP_RD,
    S_UP_CMP,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_STEPDN,
    S_SWAP,
    S_PLACE,
    S_TOP_RD,
    S_DONE
  } fsm_e;

endpackage

/* src/imh_ram.sv */
module imh_ram #(
  parameter int Depth = 1024,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* src/indexed_max_heap_with_handles.sv */
// Flow: a word is looked up, then sifted up or down level by level as needed, then finished
//   with a root read and the done_o strobe; full, empty and stale words go from the lookup
//   straight to the root read.
// Throughput: one word at a time, set by one shared comparator;
//   busy stays high through the strobe, so the next word goes in the cycle after it.
// Reset: rst_ni async active low clears the state, counts, stack depth and fresh-handle counter only.
// The receiver cannot stall: each result shows for exactly one cycle with done_o.
module indexed_max_heap_with_handles #(
  parameter int CAPACITY = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command_i,
  input  logic [KEY_BITS-1:0] key_i,
  input  logic [9:0]          handle_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [9:0]          result_handle_o,
  output logic [KEY_BITS-1:0] result_key_o,
  output logic [10:0]         entry_count_o,
  output logic [KEY_BITS-1:0] top_key_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [KEY_BITS-1:0] Sign = {1'b1, {(KEY_BITS-1){1'b0}}};

  imh_pkg::fsm_e state_q, state_d;

  // Keys are held biased (sign flipped) so an unsigned compare orders them.
  logic          kwe, hwe, swe, rwe;
  logic [AW-1:0] kwa, kra, hwa, hra, swa, sra, rra;
  logic [KEY_BITS-1:0] kwd, krd;
  logic [AW-1:0] hwd, hrd, swd, srd, rrd;
  logic [AW-1:0] rrd_wa, rrd_wd;

  imh_ram #(.Depth(CAPACITY), .Width(KEY_BITS)) u_keys (
    .clk_i, .we_i(kwe), .waddr_i(kwa), .wdata_i(kwd), .raddr_i(kra), .rdata_o(krd));
  imh_ram #(.Depth(CAPACITY), .Width(AW)) u_shdl (
    .clk_i, .we_i(hwe), .waddr_i(hwa), .wdata_i(hwd), .raddr_i(hra), .rdata_o(hrd));
  imh_ram #(.Depth(CAPACITY), .Width(AW)) u_hslot (
    .clk_i, .we_i(swe), .waddr_i(swa), .wdata_i(swd), .raddr_i(sra), .rdata_o(srd));
  imh_ram #(.Depth(CAPACITY), .Width(AW)) u_stack (
    .clk_i, .we_i(rwe), .waddr_i(rrd_wa), .wdata_i(rrd_wd), .raddr_i(rra), .rdata_o(rrd));

  // A handle is live when it has been issued, its slot is in use and that slot points
  // back at it: slots below the count always hold exactly the live handles.
  logic [CW-1:0] depth_q, depth_d, fresh_q, fresh_d, cnt_q, cnt_d;
  logic [1:0]    cmd_q;
  logic [9:0]    handle_q_full;
  logic [KEY_BITS-1:0] key_q, key_d, old_q, old_d, ck_q, ck_d, ik_q, ik_d;
  logic [AW-1:0] hdl_q, hdl_d, ih_q, ih_d, ch_q, ch_d;
  logic [CW:0]   i_q, i_d, c_q, c_d;
  logic [1:0]    st_q, st_d;
  logic [9:0]    rh_q, rh_d;
  logic [KEY_BITS-1:0] rk_q, rk_d;
  logic          up_q, up_d, step_q, step_d;

  // shared comparator
  logic [KEY_BITS-1:0] ca, cb;
  logic lt;
  assign lt = ca < cb;

  logic [CW:0] l_idx;
  assign l_idx = {i_q[CW-1:0], 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= imh_pkg::S_IDLE;
      depth_q <= '0;
      fresh_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      fresh_q <= fresh_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == imh_pkg::S_IDLE) cmd_q <= command_i;
    key_q <= key_d; old_q <= old_d; ck_q <= ck_d; ik_q <= ik_d;
    hdl_q <= hdl_d; ih_q <= ih_d; ch_q <= ch_d; i_q <= i_d; c_q <= c_d;
    st_q <= st_d; rh_q <= rh_d; rk_q <= rk_d; up_q <= up_d; step_q <= step_d;
  end

  always_comb begin
    state_d = state_q;
    depth_d = depth_q; fresh_d = fresh_q; cnt_d = cnt_q;
    key_d = key_q; old_d = old_q; ck_d = ck_q; ik_d = ik_q;
    hdl_d = hdl_q; ih_d = ih_q; ch_d = ch_q; i_d = i_q; c_d = c_q;
    st_d = st_q; rh_d = rh_q; rk_d = rk_q; up_d = up_q; step_d = step_q;
    kwe = 1'b0; hwe = 1'b0; swe = 1'b0; rwe = 1'b0;
    kwa = '0; kwd = '0; kra = '0; hwa = '0; hwd = '0; hra = '0;
    swa = '0; swd = '0; sra = '0; rra = '0; rrd_wa = '0; rrd_wd = '0;
    ca = '0; cb = '0;
    done_o = 1'b0;
    case (state_q)
      imh_pkg::S_IDLE: begin
        if (start) begin
          key_d = key_i ^ Sign;
          hdl_d = handle_i[AW-1:0];
          st_d = imh_pkg::ST_OK; rh_d = '0; rk_d = '0;
          rra = AW'(depth_q - CW'(1));
          sra = handle_i[AW-1:0];
          kra = '0; hra = '0;
          state_d = imh_pkg::S_CHK;
        end
      end
      imh_pkg::S_CHK: begin
        // rrd = stack top, srd = slot of handle, krd/hrd = root
        case (cmd_q)
          imh_pkg::CMD_INSERT: begin
            if (cnt_q >= CW'(CAPACITY) ||
                (depth_q == '0 && fresh_q >= CW'(CAPACITY))) begin
              st_d = imh_pkg::ST_FULL; state_d = imh_pkg::S_TOP_RD;
            end else begin
              if (depth_q != '0) begin
                ih_d = rrd; depth_d = depth_q - CW'(1);
              end else begin
                ih_d = fresh_q[AW-1:0]; fresh_d = fresh_q + CW'(1);
              end
              state_d = imh_pkg::S_INS;
            end
          end
          imh_pkg::CMD_EXTRACT: begin
            if (cnt_q == '0) begin
              st_d = imh_pkg::ST_EMPTY; state_d = imh_pkg::S_TOP_RD;
            end else begin
              rh_d = 10'(hrd); rk_d = krd ^ Sign; hdl_d = hrd;
              kra = AW'(cnt_q - CW'(1)); hra = AW'(cnt_q - CW'(1));
              state_d = imh_pkg::S_EXT_RD;
            end
          end
          default: begin
            // never issued, or its slot is past the end
            if ((32'(handle_q_full) >= 32'(fresh_q)) || (CW'(srd) >= cnt_q)) begin
              st_d = imh_pkg::ST_STALE; state_d = imh_pkg::S_TOP_RD;
            end else begin
              i_d = (CW+1)'(srd);
              kra = srd; hra = srd;
              state_d = imh_pkg::S_CHK2;
            end
          end
        endcase
      end
      imh_pkg::S_CHK2: begin
        old_d = krd;
        if (hrd != hdl_q) begin
          // slot now owned by another handle: this one was freed
          st_d = imh_pkg::ST_STALE; state_d = imh_pkg::S_TOP_RD;
        end else if (cmd_q == imh_pkg::CMD_CHANGE) begin
          kwe = 1'b1; kwa = i_q[AW-1:0]; kwd = key_q;
          ca = key_q; cb = krd;
          ik_d = key_q;
          up_d = !lt;
          step_d = (key_q != krd);
          kra = i_q[AW-1:0]; hra = i_q[AW-1:0];
          state_d = imh_pkg::S_CHG;
        end else begin
          if (depth_q < CW'(CAPACITY)) begin
            rwe = 1'b1; rrd_wa = depth_q[AW-1:0]; rrd_wd = hdl_q;
            depth_d = depth_q + CW'(1);
          end
          cnt_d = cnt_q - CW'(1);
          kra = AW'(cnt_q - CW'(1)); hra = AW'(cnt_q - CW'(1));
          state_d = imh_pkg::S_ERA_RD;
        end
      end
      imh_pkg::S_CHG: begin
        ih_d = hrd;
        if (!step_q) state_d = imh_pkg::S_TOP_RD;
        else if (up_q) state_d = imh_pkg::S_UP_RD;
        else state_d = imh_pkg::S_DN_RDL;
      end
      imh_pkg::S_INS: begin
        kwe = 1'b1; kwa = cnt_q[AW-1:0]; kwd = key_q;
        hwe = 1'b1; hwa = cnt_q[AW-1:0]; hwd = ih_q;
        swe = 1'b1; swa = ih_q; swd = cnt_q[AW-1:0];
        rh_d = 10'(ih_q);
        ik_d = key_q;
        i_d = (CW+1)'(cnt_q);
        cnt_d = cnt_q + CW'(1);
        state_d = imh_pkg::S_UP_RD;
      end
      imh_pkg::S_EXT_RD: begin
        if (depth_q < CW'(CAPACITY)) begin
          rwe = 1'b1; rrd_wa = depth_q[AW-1:0]; rrd_wd = hdl_q;
          depth_d = depth_q + CW'(1);
        end
        ik_d = krd; ih_d = hrd;
        cnt_d = cnt_q - CW'(1);
        state_d = imh_pkg::S_EXT_WR;
      end
      imh_pkg::S_EXT_WR: begin
        kwe = 1'b1; kwa = '0; kwd = ik_q;
        hwe = 1'b1; hwa = '0; hwd = ih_q;
        swe = 1'b1; swa = ih_q; swd = '0;
        i_d = '0;
        state_d = (cnt_q == '0) ? imh_pkg::S_TOP_RD : imh_pkg::S_DN_RDL;
      end
      imh_pkg::S_ERA_RD: begin
        ik_d = krd; ih_d = hrd;
        if (i_q == (CW+1)'(cnt_q)) state_d = imh_pkg::S_TOP_RD;
        else state_d = imh_pkg::S_ERA_WR;
      end
      imh_pkg::S_ERA_WR: begin
        kwe = 1'b1; kwa = i_q[AW-1:0]; kwd = ik_q;
        hwe = 1'b1; hwa = i_q[AW-1:0]; hwd = ih_q;
        swe = 1'b1; swa = ih_q; swd = i_q[AW-1:0];
        ca = ik_q; cb = old_q;
        if (lt) state_d = imh_pkg::S_DN_RDL;
        else if (ik_q != old_q) state_d = imh_pkg::S_UP_RD;
        else state_d = imh_pkg::S_TOP_RD;
      end
      // moving element (ik,ih) sits at slot i; read parent
      imh_pkg::S_UP_RD: begin
        if (i_q == '0) state_d = imh_pkg::S_TOP_RD;
        else begin
          c_d = (i_q - (CW+1)'(1)) >> 1;
          kra = AW'((i_q - (CW+1)'(1)) >> 1); hra = AW'((i_q - (CW+1)'(1)) >> 1);
          state_d = imh_pkg::S_UP_CMP;
        end
      end
      imh_pkg::S_UP_CMP: begin
        ca = krd; cb = ik_q;
        ck_d = krd; ch_d = hrd;
        state_d = lt ? imh_pkg::S_SWAP : imh_pkg::S_TOP_RD;
        up_d = 1'b1;
      end
      imh_pkg::S_DN_RDL: begin
        up_d = 1'b0;
        if (l_idx >= (CW+1)'(cnt_q)) state_d = imh_pkg::S_TOP_RD;
        else begin
          kra = l_idx[AW-1:0]; hra = l_idx[AW-1:0];
          c_d = l_idx;
          state_d = imh_pkg::S_DN_RDR;
        end
      end
      imh_pkg::S_DN_RDR: begin
        ck_d = krd; ch_d = hrd;
        kra = AW'(c_q + (CW+1)'(1)); hra = AW'(c_q + (CW+1)'(1));
        state_d = imh_pkg::S_DN_CMP;
        step_d = (c_q + (CW+1)'(1)) < (CW+1)'(cnt_q);
      end
      imh_pkg::S_DN_CMP: begin
        ca = ck_q; cb = krd;
        if (step_q && lt) begin
          ck_d = krd; ch_d = hrd; c_d = c_q + (CW+1)'(1);
          state_d = imh_pkg::S_STEPDN;
        end else begin
          state_d = imh_pkg::S_STEPDN;
        end
      end
      imh_pkg::S_STEPDN: begin
        ca = ik_q; cb = ck_q;
        state_d = lt ? imh_pkg::S_SWAP : imh_pkg::S_TOP_RD;
      end
      imh_pkg::S_SWAP: begin
        // child/parent (ck,ch) at c goes to i; mover goes to c
        kwe = 1'b1; kwa = i_q[AW-1:0]; kwd = ck_q;
        hwe = 1'b1; hwa = i_q[AW-1:0]; hwd = ch_q;
        swe = 1'b1; swa = ch_q; swd = i_q[AW-1:0];
        i_d = c_q;
        state_d = imh_pkg::S_PLACE;
      end
      imh_pkg::S_PLACE: begin
        kwe = 1'b1; kwa = i_q[AW-1:0]; kwd = ik_q;
        hwe = 1'b1; hwa = i_q[AW-1:0]; hwd = ih_q;
        swe = 1'b1; swa = ih_q; swd = i_q[AW-1:0];
        state_d = up_q ? imh_pkg::S_UP_RD : imh_pkg::S_DN_RDL;
      end
      imh_pkg::S_TOP_RD: begin
        kra = '0;
        state_d = imh_pkg::S_DONE;
      end
      imh_pkg::S_DONE: begin
        done_o = 1'b1;
        state_d = imh_pkg::S_IDLE;
      end
      default: state_d = imh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == imh_pkg::S_IDLE) handle_q_full <= handle_i;
  end

  assign busy            = (state_q != imh_pkg::S_IDLE);
  assign status_o        = st_q;
  assign result_handle_o = rh_q;
  assign result_key_o    = rk_q;
  assign entry_count_o   = 11'(cnt_q);
  // root read in S_TOP_RD lands in krd during the strobe cycle
  assign top_key_o       = (cnt_q == '0) ? '0 : (krd ^ Sign);

endmodule

/* src/imh_checker.sv */
module imh_sva (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [10:0] entry_count_o,
  input logic [31:0] top_key_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("strobe while idle");
  a_done_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe held");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");
  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && entry_count_o == 11'd0) |-> top_key_o == 32'd0) else $error("top nonzero");
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == imh_pkg::ST_EMPTY) |-> entry_count_o == 11'd0)
    else $error("empty status with entries");

endmodule

bind indexed_max_heap_with_handles imh_sva u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .status_o, .entry_count_o, .top_key_o);

/* tb/sv/imh_checker.sv */
module imh_scoreboard (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         command_i,
  input  logic [31:0]        key_i,
  input  logic [9:0]         handle_i,
  input  logic               done_o,
  input  logic [1:0]         status_o,
  input  logic [9:0]         result_handle_o,
  input  logic [31:0]        result_key_o,
  input  logic [10:0]        entry_count_o,
  input  logic [31:0]        top_key_o,
  output int                 fail_cnt_o,
  output int                 pending_o,
  output int                 result_cnt_o,
  output int                 full_cnt_o,
  output int                 empty_cnt_o,
  output int                 stale_cnt_o
);

  localparam int CAP = 1024;

  typedef struct {
    imh_pkg::status_e   st;
    logic [9:0]         rh;
    logic signed [31:0] rk;
    logic [10:0]        cnt;
    logic signed [31:0] top;
  } heap_resp_t;

  // shadow heap
  logic signed [31:0] key_at   [CAP];
  logic [9:0]         owner_at [CAP];
  int                 slot_of  [CAP];
  bit                 is_live  [CAP];
  logic [9:0]         free_stk [CAP];
  int                 free_depth, next_fresh, live;

  heap_resp_t expected_q[$];

  task automatic exchange(input int a, input int b);
    logic signed [31:0] k;
    logic [9:0]         h;
    k = key_at[a]; h = owner_at[a];
    key_at[a] = key_at[b]; owner_at[a] = owner_at[b];
    key_at[b] = k; owner_at[b] = h;
    slot_of[owner_at[a]] = a;
    slot_of[owner_at[b]] = b;
  endtask

  task automatic sift_up(input int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!(key_at[p] < key_at[i])) break;
      exchange(i, p);
      i = p;
    end
  endtask

  // right child wins only when the left is strictly smaller
  task automatic sift_down(input int i);
    int l, r, c;
    while (i < live) begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      if (l >= live) break;
      c = l;
      if (r < live && key_at[l] < key_at[r]) c = r;
      if (!(key_at[i] < key_at[c])) break;
      exchange(i, c);
      i = c;
    end
  endtask

  task automatic free_handle(input int h);
    is_live[h] = 1'b0;
    if (free_depth < CAP) begin
      free_stk[free_depth] = 10'(h);
      free_depth++;
    end
  endtask

  task automatic apply_word(input imh_pkg::cmd_e cmd, input logic signed [31:0] key,
                            input logic [9:0] h, output heap_resp_t r);
    int s, nh, last;
    logic signed [31:0] old, mk;
    r.st = imh_pkg::ST_OK; r.rh = '0; r.rk = '0;
    case (cmd)
      imh_pkg::CMD_INSERT: begin
        if (live >= CAP) r.st = imh_pkg::ST_FULL;
        else begin
          if (free_depth > 0) begin
            free_depth--;
            nh = int'(free_stk[free_depth]);
          end else if (next_fresh < CAP) begin
            nh = next_fresh;
            next_fresh++;
          end else nh = CAP;
          if (nh >= CAP) r.st = imh_pkg::ST_FULL;
          else begin
            s = live;
            live++;
            key_at[s] = key; owner_at[s] = 10'(nh);
            slot_of[nh] = s; is_live[nh] = 1'b1;
            sift_up(s);
            r.rh = 10'(nh);
          end
        end
      end
      imh_pkg::CMD_EXTRACT: begin
        if (live == 0) r.st = imh_pkg::ST_EMPTY;
        else begin
          r.rh = owner_at[0];
          r.rk = key_at[0];
          free_handle(int'(owner_at[0]));
          last = live - 1;
          key_at[0] = key_at[last]; owner_at[0] = owner_at[last];
          slot_of[owner_at[0]] = 0;
          live = last;
          if (live > 0) sift_down(0);
        end
      end
      default: begin
        if (!is_live[h] || slot_of[h] >= live) r.st = imh_pkg::ST_STALE;
        else if (cmd == imh_pkg::CMD_CHANGE) begin
          s = slot_of[h];
          old = key_at[s];
          key_at[s] = key;
          if (key < old) sift_down(s);
          else if (old < key) sift_up(s);
        end else begin
          s = slot_of[h];
          last = live - 1;
          old = key_at[s];
          free_handle(int'(h));
          live = last;
          // hole refilled from the last slot, then sifted down or up if its key differs
          if (s != last) begin
            mk = key_at[last];
            key_at[s] = mk; owner_at[s] = owner_at[last];
            slot_of[owner_at[s]] = s;
            if (mk < old) sift_down(s);
            else if (old < mk) sift_up(s);
          end
        end
      end
    endcase
    r.cnt = 11'(live);
    r.top = (live > 0) ? key_at[0] : '0;
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_cnt_o = fail_cnt_o + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heap_resp_t e;
    if (!rst_ni) begin
      for (int i = 0; i < CAP; i++) is_live[i] = 1'b0;
      free_depth = 0; next_fresh = 0; live = 0;
      expected_q.delete();
      fail_cnt_o = 0;
      pending_o <= 0; result_cnt_o <= 0;
      full_cnt_o <= 0; empty_cnt_o <= 0; stale_cnt_o <= 0;
    end else begin
      if (done_o) begin
        result_cnt_o <= result_cnt_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got status %0d",
                   $time, status_o);
          fail_cnt_o = fail_cnt_o + 1;
        end else begin
          e = expected_q.pop_front();
          check_field("status", 32'(e.st), 32'(status_o));
          check_field("result_handle", 32'(e.rh), 32'(result_handle_o));
          check_field("result_key", e.rk, result_key_o);
          check_field("entry_count", 32'(e.cnt), 32'(entry_count_o));
          check_field("top_key", e.top, top_key_o);
        end
      end
      if (start && !busy) begin
        apply_word(imh_pkg::cmd_e'(command_i), key_i, handle_i, e);
        expected_q.insert(expected_q.size(), e);
        if (e.st == imh_pkg::ST_FULL)  full_cnt_o  <= full_cnt_o + 1;
        if (e.st == imh_pkg::ST_EMPTY) empty_cnt_o <= empty_cnt_o + 1;
        if (e.st == imh_pkg::ST_STALE) stale_cnt_o <= stale_cnt_o + 1;
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

/* tb/sv/tb_indexed_max_heap_with_handles.sv */
module tb_indexed_max_heap_with_handles;

  localparam int LIMIT = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = imh_pkg::CMD_INSERT;
  logic [31:0] key_i = '0;
  logic [9:0]  handle_i = '0;
  logic        done_o;
  logic [1:0]  status_o;
  logic [9:0]  result_handle_o;
  logic [31:0] result_key_o;
  logic [10:0] entry_count_o;
  logic [31:0] top_key_o;

  int fail_cnt, pending, result_cnt, full_cnt, empty_cnt, stale_cnt;
  int cycles = 0;
  int word_idx = 0;   // words sent so far; steers the no-idle stretch
  bit no_idle = 1'b0;

  // handles recently returned in results, so change/erase mostly hit live entries
  logic [9:0] handle_pool [64];
  int         pool_fill = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  indexed_max_heap_with_handles dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_i, .handle_i,
    .done_o, .status_o, .result_handle_o, .result_key_o, .entry_count_o, .top_key_o
  );

  imh_scoreboard chk (
    .clk_i, .rst_ni, .start, .busy, .command_i, .key_i, .handle_i,
    .done_o, .status_o, .result_handle_o, .result_key_o, .entry_count_o, .top_key_o,
    .fail_cnt_o(fail_cnt), .pending_o(pending), .result_cnt_o(result_cnt),
    .full_cnt_o(full_cnt), .empty_cnt_o(empty_cnt), .stale_cnt_o(stale_cnt)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // collect the result handle of every OK word; inserts and extracts hand them out
  always @(posedge clk_i) begin
    if (done_o && status_o == imh_pkg::ST_OK) begin
      handle_pool[pool_fill % 64] <= result_handle_o;
      pool_fill <= pool_fill + 1;
    end
  end

  // one word: optional idle gap, then hold start until the edge that takes it
  task automatic send_word(input imh_pkg::cmd_e cmd, input logic [31:0] key,
                           input logic [9:0] h);
    bit b;
    if (!no_idle && $urandom_range(99) < 37) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 37);
    end
    start     <= 1'b1;
    command_i <= cmd;
    key_i     <= key;
    handle_i  <= h;
    do begin
      @(negedge clk_i) b = busy;
      @(posedge clk_i);
    end while (b);
    word_idx++;
  endtask

  task automatic drain_all();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(3))
      0:       rand_key = $urandom;
      1:       rand_key = $urandom_range(16) - 8;   // dense, lots of ties
      2:       rand_key = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: rand_key = $urandom_range(2000) - 1000;
    endcase
  endfunction

  function automatic logic [9:0] rand_handle();
    if (pool_fill == 0 || $urandom_range(99) < 15) rand_handle = 10'($urandom);
    else rand_handle = handle_pool[$urandom_range((pool_fill < 64 ? pool_fill : 64) - 1)];
  endfunction

  task automatic random_words(input int n);
    int r;
    imh_pkg::cmd_e c;
    repeat (n) begin
      no_idle = (word_idx >= 150 && word_idx < 350);
      r = $urandom_range(99);
      c = (r < 35) ? imh_pkg::CMD_INSERT : (r < 60) ? imh_pkg::CMD_EXTRACT :
          (r < 85) ? imh_pkg::CMD_CHANGE : imh_pkg::CMD_ERASE;
      send_word(c, rand_key(), rand_handle());
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty and stale cases on a fresh heap
    send_word(imh_pkg::CMD_EXTRACT, 32'd0, 10'd0);
    send_word(imh_pkg::CMD_CHANGE, 32'd5, 10'd0);
    send_word(imh_pkg::CMD_ERASE, 32'd0, 10'h3ff);
    // handles 0..4 come out fresh in order
    send_word(imh_pkg::CMD_INSERT, 32'd10, 10'd0);
    send_word(imh_pkg::CMD_INSERT, 32'h7fff_ffff, 10'd0);
    send_word(imh_pkg::CMD_INSERT, 32'd10, 10'd0);            // tie with handle 0
    send_word(imh_pkg::CMD_INSERT, 32'h8000_0000, 10'd0);
    send_word(imh_pkg::CMD_INSERT, 32'hffff_ffff, 10'd0);
    send_word(imh_pkg::CMD_CHANGE, 32'd10, 10'd2);            // same key, nothing moves
    send_word(imh_pkg::CMD_CHANGE, 32'h7fff_ffff, 10'd0);     // raise to a tie at the top
    send_word(imh_pkg::CMD_CHANGE, 32'h8000_0000, 10'd1);     // drop the max to the floor
    send_word(imh_pkg::CMD_ERASE, 32'd0, 10'd4);              // entry in slot 1, not the last slot
    send_word(imh_pkg::CMD_ERASE, 32'd0, 10'd0);              // hole refilled from the tail
    send_word(imh_pkg::CMD_ERASE, 32'd0, 10'd0);              // now stale
    send_word(imh_pkg::CMD_CHANGE, 32'd1, 10'd4);             // stale too
    send_word(imh_pkg::CMD_INSERT, 32'd3, 10'd0);             // reuses handle 0 (LIFO)
    send_word(imh_pkg::CMD_INSERT, 32'd3, 10'd0);             // reuses handle 4
    send_word(imh_pkg::CMD_INSERT, 32'h5555_aaaa, 10'h2aa);
    send_word(imh_pkg::CMD_CHANGE, 32'haaaa_5555, 10'h155);
    repeat (7) send_word(imh_pkg::CMD_EXTRACT, 32'd0, 10'd0); // drain past empty

    random_words(250);

    // let everything land, then fill to capacity and past it
    drain_all();
    repeat (1030) send_word(imh_pkg::CMD_INSERT, rand_key(), 10'd0);
    repeat (20)   send_word(imh_pkg::cmd_e'($urandom_range(3)), rand_key(), rand_handle());
    repeat (60)   send_word(imh_pkg::CMD_EXTRACT, 32'd0, 10'd0);

    random_words(160);
    start <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("covered %0d words, %0d results checked", word_idx, result_cnt);
    $display("status hits: full %0d, empty %0d, stale %0d", full_cnt, empty_cnt, stale_cnt);
    if (fail_cnt == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
